@@ rtl/pdc_pkg.sv @@
package pdc_pkg;

   // field widths
   localparam int WORD_W = 32;
   localparam int DUTY_W = 7;
   localparam int GAIN_W = 32;
   localparam int CSR_IDX_W = 3;

   // bit-serial multiply-accumulate unit
   localparam int MULT_W = 40;                // widest multiplier operand: 125 * delta error
   localparam int SUM_W = 74;                 // running sum, two's complement
   localparam int PP_W = GAIN_W + 2;          // partial product, signed
   localparam int STEP_CNT_W = $clog2(SUM_W);

   // bit-serial divider for the integral update
   localparam int DIV_W = 44;                 // magnitude of integral * 1000 + error * 16
   localparam int DIVISOR = 1000;
   localparam int REM_W = $clog2(DIVISOR);
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // arithmetic constants
   localparam int FRAC_BITS = 29;
   localparam int VEL_OFFSET = 12500;
   localparam int ERR_SCALE = 16;
   localparam int DUTY_MAX = 100;

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_DUTY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY_MODE = 3'd4;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = 32'd1342177280;

   // request commands
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;    // zero the running sum
      logic start;    // begin one pass
      logic negate;   // pass replaces the sum by its negation
   } mac_ctl_type;

endpackage

@@ rtl/pid_duty_cycle_controller_top.sv @@
// PID duty-cycle controller. An encoder update beat (command 0) latches the two
// wheel velocities and distances and returns nothing. A control tick beat
// (command 1) forms the error, updates the integral when the error is nonzero,
// takes the derivative, combines the three terms with the Q4.28 gains plus the
// base duty, and returns one duty cycle clamped to 0..100. One item is worked
// on at a time. All products but the derivative's 125 * delta go through one
// bit-serial multiply-accumulate unit that walks the full 74-bit running sum on
// every pass, and the integral update divides by 1000 in a bit-serial divider;
// a negative scaled integral needs an extra negation pass first. A finished
// duty cycle waits in the output register, so the next beat can be taken
// while it is still unread.
module pid_duty_cycle_controller_top (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic signed [pdc_pkg::WORD_W-1:0]  req_left_velocity,
   input  logic signed [pdc_pkg::WORD_W-1:0]  req_right_velocity,
   input  logic signed [pdc_pkg::WORD_W-1:0]  req_left_distance,
   input  logic signed [pdc_pkg::WORD_W-1:0]  req_right_distance,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pdc_pkg::DUTY_W-1:0]         rsp_duty_cycle,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdc_pkg::GAIN_W-1:0]         csr_data
);

   localparam int WW = pdc_pkg::WORD_W;
   localparam int MW = pdc_pkg::MULT_W;
   localparam int SW = pdc_pkg::SUM_W;
   localparam int GW = pdc_pkg::GAIN_W;
   localparam int DTW = pdc_pkg::DUTY_W;
   localparam int FB = pdc_pkg::FRAC_BITS;

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_ERR      = 4'd1;
   localparam logic [3:0] ST_PASS     = 4'd2;
   localparam logic [3:0] ST_WAIT     = 4'd3;
   localparam logic [3:0] ST_DIV      = 4'd4;
   localparam logic [3:0] ST_DIV_WAIT = 4'd5;
   localparam logic [3:0] ST_INTEG    = 4'd6;
   localparam logic [3:0] ST_DERIV1   = 4'd7;
   localparam logic [3:0] ST_DERIV2   = 4'd8;
   localparam logic [3:0] ST_DERIV3   = 4'd9;
   localparam logic [3:0] ST_OUT      = 4'd10;

   // multiply-accumulate passes
   localparam logic [2:0] PASS_N_SCALE = 3'd0;  // 1000 * integral
   localparam logic [2:0] PASS_N_ERR   = 3'd1;  // + 16 * error
   localparam logic [2:0] PASS_N_ABS   = 3'd2;  // negate when below zero
   localparam logic [2:0] PASS_PROP    = 3'd3;
   localparam logic [2:0] PASS_INTEG   = 3'd4;
   localparam logic [2:0] PASS_DERIV   = 3'd5;
   localparam logic [2:0] PASS_BASE    = 3'd6;

   logic [3:0]            state_ff, state_in;
   logic [2:0]            pass_ff, pass_in;

   logic [GW-1:0]         prop_gain_ff, prop_gain_in;
   logic [GW-1:0]         integ_gain_ff, integ_gain_in;
   logic [GW-1:0]         deriv_gain_ff, deriv_gain_in;
   logic [DTW-1:0]        base_duty_ff, base_duty_in;
   logic                  velocity_mode_ff, velocity_mode_in;

   pdc_pkg::word_type     left_vel_ff, left_vel_in;
   pdc_pkg::word_type     right_vel_ff, right_vel_in;
   pdc_pkg::word_type     left_dist_ff, left_dist_in;
   pdc_pkg::word_type     right_dist_ff, right_dist_in;
   pdc_pkg::word_type     integ_ff, integ_in;
   pdc_pkg::word_type     prev_err_ff, prev_err_in;

   pdc_pkg::word_type     err_ff, err_in;
   logic signed [WW:0]    diff_ff, diff_in;
   logic signed [MW-1:0]  dscale_ff, dscale_in;
   logic                  n_neg_ff, n_neg_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DTW-1:0]        rsp_duty_ff, rsp_duty_in;

   logic signed [WW+1:0]  err_wide;
   pdc_pkg::word_type     err_sat;
   logic signed [MW-1:0]  diff_ext;
   logic [DTW-1:0]        duty_calc;
   logic                  sum_big;
   logic [WW-1:0]         quo_low;
   logic                  quo_over;

   pdc_pkg::mac_ctl_type  mac_ctl;
   logic [GW-1:0]         mac_gain;
   logic signed [MW-1:0]  mac_mult;
   logic                  mac_busy;
   logic [SW-1:0]         mac_sum;

   logic                  div_start;
   logic                  div_busy;
   logic [pdc_pkg::DIV_W-1:0] div_quo;

   pdc_serial_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .gain  (mac_gain),
      .mult  (mac_mult),
      .busy  (mac_busy),
      .sum   (mac_sum)
   );

   pdc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mac_sum[pdc_pkg::DIV_W-1:0]),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // error from the stored encoder values, saturated to 32 bits
   always_comb begin
      if (velocity_mode_ff) begin
         err_wide = {{2{left_vel_ff[WW-1]}}, left_vel_ff}
                  - {{2{right_vel_ff[WW-1]}}, right_vel_ff}
                  + (WW + 2)'(pdc_pkg::VEL_OFFSET);
      end else begin
         err_wide = {{2{right_dist_ff[WW-1]}}, right_dist_ff}
                  - {{2{left_dist_ff[WW-1]}}, left_dist_ff};
      end
      if ((err_wide[WW+1:WW-1] == 3'b000) || (err_wide[WW+1:WW-1] == 3'b111)) begin
         err_sat = err_wide[WW-1:0];
      end else begin
         err_sat = err_wide[WW+1] ? pdc_pkg::WORD_MIN : pdc_pkg::WORD_MAX;
      end
   end

   // operands of each multiply-accumulate pass
   always_comb begin
      mac_gain = '0;
      mac_mult = '0;
      case (pass_ff)
         PASS_N_SCALE: begin
            mac_gain = GW'(pdc_pkg::DIVISOR);
            mac_mult = {{(MW - WW){integ_ff[WW-1]}}, integ_ff};
         end
         PASS_N_ERR: begin
            mac_gain = GW'(pdc_pkg::ERR_SCALE);
            mac_mult = {{(MW - WW){err_ff[WW-1]}}, err_ff};
         end
         PASS_PROP: begin
            mac_gain = prop_gain_ff;
            mac_mult = {{(MW - WW - 1){err_ff[WW-1]}}, err_ff, 1'b0};
         end
         PASS_INTEG: begin
            mac_gain = integ_gain_ff;
            mac_mult = {{(MW - WW - 1){integ_ff[WW-1]}}, integ_ff, 1'b0};
         end
         PASS_DERIV: begin
            mac_gain = deriv_gain_ff;
            mac_mult = dscale_ff;
         end
         PASS_BASE: begin
            mac_gain = {{(GW - DTW){1'b0}}, base_duty_ff};
            mac_mult = MW'(1) << FB;
         end
         default: begin
            mac_gain = '0;
            mac_mult = '0;
         end
      endcase
   end

   // final clamp and the saturated integral from the divider
   always_comb begin
      sum_big = (|mac_sum[SW-2:FB+DTW]) || (mac_sum[FB +: DTW] >= DTW'(pdc_pkg::DUTY_MAX));
      if (mac_sum[SW-1]) begin
         duty_calc = '0;
      end else if (sum_big) begin
         duty_calc = DTW'(pdc_pkg::DUTY_MAX);
      end else begin
         duty_calc = mac_sum[FB +: DTW];
      end
      quo_over = |div_quo[pdc_pkg::DIV_W-1:WW-1];
      quo_low = div_quo[WW-1:0];
      diff_ext = {{(MW - WW - 1){diff_ff[WW]}}, diff_ff};
   end

   // sequencer, registers and handshakes
   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      prop_gain_in = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      base_duty_in = base_duty_ff;
      velocity_mode_in = velocity_mode_ff;
      left_vel_in = left_vel_ff;
      right_vel_in = right_vel_ff;
      left_dist_in = left_dist_ff;
      right_dist_in = right_dist_ff;
      integ_in = integ_ff;
      prev_err_in = prev_err_ff;
      err_in = err_ff;
      diff_in = diff_ff;
      dscale_in = dscale_ff;
      n_neg_in = n_neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_duty_in = rsp_duty_ff;
      mac_ctl = '0;
      div_start = 1'b0;

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            pdc_pkg::REG_PROP_GAIN:     prop_gain_in = csr_data;
            pdc_pkg::REG_INTEG_GAIN:    integ_gain_in = csr_data;
            pdc_pkg::REG_DERIV_GAIN:    deriv_gain_in = csr_data;
            pdc_pkg::REG_BASE_DUTY:     base_duty_in = csr_data[DTW-1:0];
            pdc_pkg::REG_VELOCITY_MODE: velocity_mode_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == pdc_pkg::CMD_UPDATE) begin
                  left_vel_in = req_left_velocity;
                  right_vel_in = req_right_velocity;
                  left_dist_in = req_left_distance;
                  right_dist_in = req_right_distance;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            err_in = err_sat;
            if (|err_sat) begin
               mac_ctl.clear = 1'b1;
               pass_in = PASS_N_SCALE;
               state_in = ST_PASS;
            end else begin
               state_in = ST_DERIV1;
            end
         end
         ST_PASS: begin
            mac_ctl.start = 1'b1;
            mac_ctl.negate = (pass_ff == PASS_N_ABS);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!mac_busy) begin
               case (pass_ff)
                  PASS_N_SCALE: begin
                     pass_in = PASS_N_ERR;
                     state_in = ST_PASS;
                  end
                  PASS_N_ERR: begin
                     n_neg_in = mac_sum[SW-1];
                     if (mac_sum[SW-1]) begin
                        pass_in = PASS_N_ABS;
                        state_in = ST_PASS;
                     end else begin
                        state_in = ST_DIV;
                     end
                  end
                  PASS_N_ABS: state_in = ST_DIV;
                  PASS_PROP: begin
                     pass_in = PASS_INTEG;
                     state_in = ST_PASS;
                  end
                  PASS_INTEG: begin
                     pass_in = PASS_DERIV;
                     state_in = ST_PASS;
                  end
                  PASS_DERIV: begin
                     pass_in = PASS_BASE;
                     state_in = ST_PASS;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = ST_INTEG;
            end
         end
         ST_INTEG: begin
            // quotient magnitude truncated toward zero; restore sign, saturate
            if (quo_over) begin
               integ_in = n_neg_ff ? pdc_pkg::WORD_MIN : pdc_pkg::WORD_MAX;
            end else begin
               integ_in = n_neg_ff ? -quo_low : quo_low;
            end
            state_in = ST_DERIV1;
         end
         ST_DERIV1: begin
            diff_in = {err_ff[WW-1], err_ff} - {prev_err_ff[WW-1], prev_err_ff};
            prev_err_in = err_ff;
            state_in = ST_DERIV2;
         end
         ST_DERIV2: begin
            // 125 * delta = 128 * delta - 2 * delta - delta
            dscale_in = (diff_ext <<< 7) - (diff_ext <<< 1);
            state_in = ST_DERIV3;
         end
         ST_DERIV3: begin
            dscale_in = dscale_ff - diff_ext;
            mac_ctl.clear = 1'b1;
            pass_in = PASS_PROP;
            state_in = ST_PASS;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in = duty_calc;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff <= PASS_N_SCALE;
         prop_gain_ff <= pdc_pkg::PROP_GAIN_RESET;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         base_duty_ff <= '0;
         velocity_mode_ff <= 1'b0;
         left_vel_ff <= '0;
         right_vel_ff <= '0;
         left_dist_ff <= '0;
         right_dist_ff <= '0;
         integ_ff <= '0;
         prev_err_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
         prop_gain_ff <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         base_duty_ff <= base_duty_in;
         velocity_mode_ff <= velocity_mode_in;
         left_vel_ff <= left_vel_in;
         right_vel_ff <= right_vel_in;
         left_dist_ff <= left_dist_in;
         right_dist_ff <= right_dist_in;
         integ_ff <= integ_in;
         prev_err_ff <= prev_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working values
   always_ff @(posedge clock) begin
      err_ff <= err_in;
      diff_ff <= diff_in;
      dscale_ff <= dscale_in;
      n_neg_ff <= n_neg_in;
      rsp_duty_ff <= rsp_duty_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_duty_cycle = rsp_duty_ff;

endmodule

@@ rtl/pdc_serial_mac.sv @@
// Bit-serial multiply-accumulate: a pass adds gain * mult to the running sum,
// or to its negation in a negation pass. The multiplier is walked LSB first,
// one bit per cycle, into a signed partial product; the bit that drops out
// goes by a one-bit adder into the sum, a shift register rotated once a pass.
module pdc_serial_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  pdc_pkg::mac_ctl_type                ctl,
   input  logic [pdc_pkg::GAIN_W-1:0]          gain,
   input  logic signed [pdc_pkg::MULT_W-1:0]   mult,
   output logic                                busy,
   output logic [pdc_pkg::SUM_W-1:0]           sum
);

   localparam int CNT_W = pdc_pkg::STEP_CNT_W;
   localparam int PPW = pdc_pkg::PP_W;
   localparam int SW = pdc_pkg::SUM_W;
   localparam int GW = pdc_pkg::GAIN_W;
   localparam logic [CNT_W-1:0] SIGN_STEP = CNT_W'(pdc_pkg::MULT_W - 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SW - 1);

   logic                      busy_ff, busy_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [GW-1:0]             gain_ff, gain_in;
   logic [pdc_pkg::MULT_W-1:0] mult_ff, mult_in;
   logic signed [PPW-1:0]     pp_ff, pp_in;
   logic                      carry_ff, carry_in;
   logic                      inv_ff, inv_in;
   logic [SW-1:0]             sum_ff, sum_in;

   logic signed [PPW:0]       gain_ext;
   logic signed [PPW:0]       addend;
   logic signed [PPW:0]       part;
   logic                      pbit, abit, sbit, cout;

   // one step: partial product add, serial add into the running sum
   always_comb begin
      gain_ext = {{(PPW + 1 - GW){1'b0}}, gain_ff};
      addend = '0;
      if (mult_ff[0]) begin
         // sign bit of the multiplier carries negative weight
         addend = (cnt_ff == SIGN_STEP) ? -gain_ext : gain_ext;
      end
      part = {pp_ff[PPW-1], pp_ff} + addend;
      pbit = part[0];
      abit = sum_ff[0] ^ inv_ff;
      sbit = abit ^ pbit ^ carry_ff;
      cout = (abit & pbit) | (abit & carry_ff) | (pbit & carry_ff);

      busy_in = busy_ff;
      cnt_in = cnt_ff;
      gain_in = gain_ff;
      mult_in = mult_ff;
      pp_in = pp_ff;
      carry_in = carry_ff;
      inv_in = inv_ff;
      sum_in = sum_ff;

      if (busy_ff) begin
         pp_in = part[PPW:1];
         mult_in = mult_ff >> 1;
         sum_in = {sbit, sum_ff[SW-1:1]};
         carry_in = cout;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end

      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         gain_in = gain;
         mult_in = mult;
         pp_in = '0;
         // negation pass: invert the sum bits and add one
         carry_in = ctl.negate;
         inv_in = ctl.negate;
      end

      if (ctl.clear) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
      mult_ff <= mult_in;
      pp_ff <= pp_in;
      carry_ff <= carry_in;
      inv_ff <= inv_in;
      sum_ff <= sum_in;
   end

   assign busy = busy_ff;
   assign sum = sum_ff;

endmodule

@@ rtl/pdc_serial_div.sv @@
// Restoring division by a constant, one quotient bit per cycle, MSB first.
// The dividend register shifts left and takes the quotient bits in at the bottom.
module pdc_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pdc_pkg::DIV_W-1:0]     dividend,
   output logic                          busy,
   output logic [pdc_pkg::DIV_W-1:0]     quotient
);

   localparam int DW = pdc_pkg::DIV_W;
   localparam int RW = pdc_pkg::REM_W;
   localparam int CNT_W = pdc_pkg::DIV_CNT_W;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DW - 1);
   localparam logic [RW:0] DIVISOR_K = (RW + 1)'(pdc_pkg::DIVISOR);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [RW-1:0]    rem_ff, rem_in;

   logic [RW:0]      trial;
   logic [RW:0]      reduced;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      fits = (trial >= DIVISOR_K);
      reduced = trial - DIVISOR_K;

      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;

      if (busy_ff) begin
         rem_in = fits ? reduced[RW-1:0] : trial[RW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end

      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ tb/pid_duty_cycle_controller_top_tb.sv @@
module pid_duty_cycle_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DUTY_W = pdc_pkg::DUTY_W;
   localparam int GAIN_W = pdc_pkg::GAIN_W;
   localparam int CSR_IDX_W = pdc_pkg::CSR_IDX_W;
   localparam int FRAC_BITS = pdc_pkg::FRAC_BITS;
   localparam int DUTY_MAX = pdc_pkg::DUTY_MAX;
   localparam int VEL_OFFSET = pdc_pkg::VEL_OFFSET;
   localparam int ERR_SCALE = pdc_pkg::ERR_SCALE;

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int SETTLE_CYCLES = 700;
   localparam int REPORT_LIMIT = 10;
   localparam int RESET_CYCLES = 9;
   localparam int INTEG_DIVISOR = 1000;
   localparam longint WORD_HI = 64'sd2147483647;
   localparam longint WORD_LO = -64'sd2147483648;
   localparam longint RECENTER_SPAN = 64'sd2000000000;

   typedef pdc_pkg::word_type word_type;
   typedef enum int {UPD_BALANCED, UPD_FULL, UPD_CORNER} update_style_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_command = pdc_pkg::CMD_UPDATE;
   word_type              req_left_velocity = '0;
   word_type              req_right_velocity = '0;
   word_type              req_left_distance = '0;
   word_type              req_right_distance = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DUTY_W-1:0]     rsp_duty_cycle;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [GAIN_W-1:0]     csr_data = '0;

   // controller shadow: settings and state
   logic [GAIN_W-1:0]     kp = pdc_pkg::PROP_GAIN_RESET;
   logic [GAIN_W-1:0]     ki = '0;
   logic [GAIN_W-1:0]     kd = '0;
   logic [DUTY_W-1:0]     duty_base = '0;
   logic                  vel_mode = 1'b0;
   word_type              enc_left_vel = '0;
   word_type              enc_right_vel = '0;
   word_type              enc_left_dist = '0;
   word_type              enc_right_dist = '0;
   word_type              integ_sum = '0;
   word_type              prev_err = '0;

   logic [DUTY_W-1:0]     duty_expected_q[$];
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;

   pid_duty_cycle_controller_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic longint sat_word(longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // exact value * mult * gain; with mult carrying a factor 2 the unit is 2^-29
   function automatic logic signed [127:0] gain_product(longint value, int mult,
                                                        logic [GAIN_W-1:0] gain);
      logic signed [127:0] wv, wm, wg;
      wv = value;
      wm = mult;
      wg = {96'd0, gain};
      return wv * wm * wg;
   endfunction

   // one control tick: updates integral and previous error, returns the duty
   function automatic logic [DUTY_W-1:0] advance_controller();
      longint err, delta;
      logic signed [127:0] acc, base_term, duty_top;
      if (vel_mode)
         err = sat_word(longint'(enc_left_vel) - longint'(enc_right_vel) + VEL_OFFSET);
      else
         err = sat_word(longint'(enc_right_dist) - longint'(enc_left_dist));
      if (err != 0)
         integ_sum = word_type'(sat_word((longint'(integ_sum) * INTEG_DIVISOR
                                          + err * ERR_SCALE) / INTEG_DIVISOR));
      delta = err - longint'(prev_err);
      prev_err = word_type'(err);
      // derivative factor 62.5 is 125 in half units
      base_term = {121'd0, duty_base};
      base_term = base_term <<< FRAC_BITS;
      acc = gain_product(err, 2, kp) + gain_product(integ_sum, 2, ki)
          + gain_product(delta, 125, kd) + base_term;
      duty_top = DUTY_MAX;
      duty_top = duty_top <<< FRAC_BITS;
      if (acc < 0) return '0;
      if (acc >= duty_top) return DUTY_W'(DUTY_MAX);
      return DUTY_W'(acc >>> FRAC_BITS);
   endfunction

   // result checker
   always @(posedge clock) begin : duty_check
      logic [DUTY_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected duty beat: got %0d", rsp_duty_cycle);
         end else begin
            want = duty_expected_q.pop_front();
            if (rsp_duty_cycle !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("duty_cycle mismatch: expected %0d, got %0d",
                           want, rsp_duty_cycle);
            end
         end
      end
   end

   // one request beat; valid stays high after acceptance unless a gap follows
   task automatic send_beat(logic cmd, word_type lv, word_type rv, word_type ld, word_type rd);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_left_velocity <= lv;
      req_right_velocity <= rv;
      req_left_distance <= ld;
      req_right_distance <= rd;
      do @(posedge clock); while (!req_ready);
      if (cmd == pdc_pkg::CMD_TICK) begin
         duty_expected_q.push_back(advance_controller());
      end else begin
         enc_left_vel = lv;
         enc_right_vel = rv;
         enc_left_dist = ld;
         enc_right_dist = rd;
      end
   endtask

   task automatic send_tick();
      send_beat(pdc_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom);
   endtask

   // hold off requests until every duty is back and the block has gone quiet
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (duty_expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pdc_pkg::REG_PROP_GAIN:     kp = data;
         pdc_pkg::REG_INTEG_GAIN:    ki = data;
         pdc_pkg::REG_DERIV_GAIN:    kd = data;
         pdc_pkg::REG_BASE_DUTY:     duty_base = data[DUTY_W-1:0];
         pdc_pkg::REG_VELOCITY_MODE: vel_mode = data[0];
         default: ;
      endcase
   endtask

   // full register set plus one write to an unmapped index
   task automatic load_settings(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                                logic [GAIN_W-1:0] d, logic [DUTY_W-1:0] base, logic vmode);
      logic [CSR_IDX_W-1:0] spare;
      spare = CSR_IDX_W'($urandom_range(int'(pdc_pkg::REG_VELOCITY_MODE) + 1,
                                        (1 << CSR_IDX_W) - 1));
      write_reg(pdc_pkg::REG_PROP_GAIN, p);
      write_reg(pdc_pkg::REG_INTEG_GAIN, i);
      write_reg(pdc_pkg::REG_DERIV_GAIN, d);
      write_reg(pdc_pkg::REG_BASE_DUTY, ($urandom << DUTY_W) | GAIN_W'(base));
      write_reg(pdc_pkg::REG_VELOCITY_MODE, ($urandom << 1) | GAIN_W'(vmode));
      write_reg(spare, $urandom);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [DUTY_W-1:0] random_base();
      case ($urandom_range(5))
         0: return '0;
         1: return DUTY_W'(DUTY_MAX);
         2: return '1;
         default: return DUTY_W'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic word_type pick_corner_word();
      case ($urandom_range(4))
         0: return pdc_pkg::WORD_MAX;
         1: return pdc_pkg::WORD_MIN;
         2: return '0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // anchor plus a small offset of random scale
   function automatic word_type near_value(word_type anchor);
      int span;
      span = 1 << $urandom_range(0, 12);
      return anchor + word_type'($urandom_range(0, 2 * span)) - word_type'(span);
   endfunction

   task automatic send_update(update_style_type style);
      word_type lv, rv, ld, rd;
      case (style)
         UPD_FULL: begin
            lv = $urandom;
            rv = $urandom;
            ld = $urandom;
            rd = $urandom;
         end
         UPD_CORNER: begin
            lv = pick_corner_word();
            rv = pick_corner_word();
            ld = pick_corner_word();
            rd = pick_corner_word();
         end
         default: begin
            // small error in both modes
            ld = $urandom;
            rd = near_value(ld);
            rv = $urandom;
            lv = near_value(rv - word_type'(VEL_OFFSET));
         end
      endcase
      send_beat(pdc_pkg::CMD_UPDATE, lv, rv, ld, rd);
   endtask

   // pick an error that pulls the integral back toward zero in one tick
   task automatic send_recenter();
      longint target;
      target = -(longint'(integ_sum) * INTEG_DIVISOR) / ERR_SCALE;
      if (target > RECENTER_SPAN) target = RECENTER_SPAN;
      if (target < -RECENTER_SPAN) target = -RECENTER_SPAN;
      send_beat(pdc_pkg::CMD_UPDATE, word_type'(target - VEL_OFFSET), '0, '0,
                word_type'(target));
      send_tick();
   endtask

   task automatic test_directed();
      send_idle_pct = 23;
      recv_idle_pct = 49;
      // reset settings: zero error gives zero duty
      send_tick();
      // proportional only, gain 5.0
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, 0, 20);
      send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, 0, 3);
      send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, 0, -5);
      send_tick();
      // distance error saturation both ways
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, pdc_pkg::WORD_MIN, pdc_pkg::WORD_MAX);
      send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, pdc_pkg::WORD_MAX, pdc_pkg::WORD_MIN);
      send_tick();

      // velocity mode with offset, unity gain
      drain_and_idle();
      load_settings(32'd1 << 28, '0, '0, 7'd50, 1'b1);
      send_beat(pdc_pkg::CMD_UPDATE, 0, VEL_OFFSET, 0, 0);
      send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, 7, VEL_OFFSET, 0, 0);
      send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, pdc_pkg::WORD_MAX, pdc_pkg::WORD_MIN, 0, 0);
      send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, pdc_pkg::WORD_MIN, pdc_pkg::WORD_MAX, 0, 0);
      send_tick();

      // base duty above the clamp
      drain_and_idle();
      load_settings('0, '0, '0, '1, 1'b0);
      send_tick();

      // all gains at full scale, back-to-back updates
      drain_and_idle();
      load_settings('1, '1, '1, 7'd100, 1'b0);
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, 0, 1);
      send_beat(pdc_pkg::CMD_UPDATE, -1, 1, 5, 4);
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, 9, 9);
      send_tick();

      // derivative only
      drain_and_idle();
      load_settings('0, '0, 32'd1 << 28, 7'd10, 1'b0);
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, 100, 101);
      send_tick();
      send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, 100, 100);
      send_tick();
   endtask

   task automatic test_random_traffic(int beats, int sidle, int ridle);
      int sent, next_reconfig, pick, reps;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      sent = 0;
      next_reconfig = 0;
      while (sent < beats) begin
         if (sent >= next_reconfig) begin
            drain_and_idle();
            load_settings(random_gain(), random_gain(), random_gain(), random_base(),
                          1'($urandom_range(1)));
            next_reconfig = sent + $urandom_range(60, 140);
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            // encoder update followed by one or two ticks
            send_update(UPD_BALANCED);
            reps = $urandom_range(1, 2);
            repeat (reps) send_tick();
            sent += 1 + reps;
         end else if (pick < 72) begin
            reps = $urandom_range(1, 3);
            repeat (reps) send_tick();
            sent += reps;
         end else if (pick < 80) begin
            send_update(UPD_FULL);
            send_tick();
            sent += 2;
         end else if (pick < 85) begin
            send_update(UPD_CORNER);
            send_tick();
            sent += 2;
         end else if (pick < 93) begin
            send_recenter();
            sent += 2;
         end else begin
            // updates that get overwritten before any tick
            reps = $urandom_range(1, 3);
            repeat (reps) send_update($urandom_range(1) ? UPD_FULL : UPD_BALANCED);
            sent += reps;
         end
      end
   endtask

   // drive the integral into both saturation limits
   task automatic test_integral_windup();
      drain_and_idle();
      load_settings('0, 32'd3, '0, 7'd50, 1'b0);
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, pdc_pkg::WORD_MAX, pdc_pkg::WORD_MIN);
      repeat (66) send_tick();
      send_beat(pdc_pkg::CMD_UPDATE, 0, 0, pdc_pkg::WORD_MIN, pdc_pkg::WORD_MAX);
      repeat (130) send_tick();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(500, 23, 49);
      test_random_traffic(500, 49, 23);
      test_random_traffic(500, 0, 0);
      test_integral_windup();
      drain_and_idle();
      if (mismatch_count == 0 && duty_expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ pid_duty_cycle_controller_top.f @@
rtl/pdc_pkg.sv
rtl/pdc_serial_mac.sv
rtl/pdc_serial_div.sv
rtl/pid_duty_cycle_controller_top.sv
tb/pid_duty_cycle_controller_top_tb.sv
